[hdl/qtl_pkg.sv]
`default_nettype none
package qtl_pkg;

    localparam int POS_W               = 13;
    localparam int KIND_W              = 6;
    localparam int RES_MAX             = 4;
    localparam int QUEUE_DEPTH         = 16;
    localparam int KW_COUNT            = 23;
    localparam int KW_TEXT_LEN         = 13;
    localparam int KW_BASE             = 4;
    localparam int WALK_STEPS          = 6;
    localparam int MAX_QUERY_LEN_DEF   = 4096;
    localparam int KEYWORD_MAX_LEN_DEF = 13;

    localparam logic [KIND_W-1:0] K_END      = 6'd0;
    localparam logic [KIND_W-1:0] K_NUM      = 6'd1;
    localparam logic [KIND_W-1:0] K_STR      = 6'd2;
    localparam logic [KIND_W-1:0] K_INV      = 6'd3;
    localparam logic [KIND_W-1:0] K_GE       = 6'd27;
    localparam logic [KIND_W-1:0] K_GT       = 6'd28;
    localparam logic [KIND_W-1:0] K_LE       = 6'd29;
    localparam logic [KIND_W-1:0] K_LT       = 6'd30;
    localparam logic [KIND_W-1:0] K_EQ       = 6'd31;
    localparam logic [KIND_W-1:0] K_FUZZY    = 6'd32;
    localparam logic [KIND_W-1:0] K_SUBSTR   = 6'd33;
    localparam logic [KIND_W-1:0] K_STARTS   = 6'd34;
    localparam logic [KIND_W-1:0] K_ENDS     = 6'd35;
    localparam logic [KIND_W-1:0] K_GLOB     = 6'd36;
    localparam logic [KIND_W-1:0] K_LPAREN   = 6'd37;
    localparam logic [KIND_W-1:0] K_RPAREN   = 6'd38;
    localparam logic [KIND_W-1:0] K_COMMA    = 6'd39;
    localparam logic [KIND_W-1:0] K_LBRACKET = 6'd40;
    localparam logic [KIND_W-1:0] K_RBRACKET = 6'd41;
    localparam logic [KIND_W-1:0] K_DOTDOT   = 6'd42;
    localparam logic [KIND_W-1:0] K_NE       = 6'd43;
    localparam logic [KIND_W-1:0] K_NFUZZY   = 6'd44;
    localparam logic [KIND_W-1:0] K_NSUBSTR  = 6'd45;
    localparam logic [KIND_W-1:0] K_NGLOB    = 6'd46;
    localparam logic [KIND_W-1:0] K_NSTARTS  = 6'd47;
    localparam logic [KIND_W-1:0] K_NENDS    = 6'd48;

    // Keyword text is right-justified: the last character sits in the low byte.
    localparam logic [KW_TEXT_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
        "priority", "tag", "status", "name", "path", "time", "deadline", "mtime",
        "any", "all", "untagged", "unstatused", "unnamed", "unprioritized",
        "undeadlined", "and", "or", "xor", "not", "allof", "anyof", "in", "has"
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd8, 4'd3, 4'd6, 4'd4, 4'd4, 4'd4, 4'd8, 4'd5, 4'd3, 4'd3, 4'd8, 4'd10,
        4'd7, 4'd13, 4'd11, 4'd3, 4'd2, 4'd3, 4'd3, 4'd5, 4'd5, 4'd2, 4'd3
    };

    typedef enum logic [2:0] {
        LM_IDLE, LM_NUM, LM_IDENT, LM_QUOTE, LM_QESC, LM_OPS
    } t_lex_mode;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       has_char;
        logic       end_of_query;
    } t_item;

    typedef struct packed {
        logic              is_token;
        logic [KIND_W-1:0] token_kind;
        logic [POS_W-1:0]  start_pos;
        logic [POS_W-1:0]  span_len;
        logic [7:0]        content_byte;
        logic              last_result;
    } t_result;

    typedef struct packed {
        logic [2:0]                count;
        t_result [RES_MAX-1:0]     res;
    } t_burst;

    typedef struct packed {
        logic              need;
        logic [KIND_W-1:0] kind;
        logic [1:0]        len;
    } t_decide;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_word_start(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == "_");
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_dig(c) || is_word_start(c);
    endfunction

    function automatic logic [7:0] kw_char(input int i, input int j);
        logic [7:0] ch;
        ch = 8'h00;
        if (j < int'(KW_LEN[i])) begin
            ch = KW_TEXT[i][(int'(KW_LEN[i]) - 1 - j) * 8 +: 8];
        end
        return ch;
    endfunction

    function automatic t_result mk_byte(input logic [7:0] cb);
        t_result r;
        r = '0;
        r.content_byte = cb;
        return r;
    endfunction

    function automatic t_burst push_res(input t_burst bu, input t_result r);
        t_burst nb;
        nb = bu;
        if (bu.count < 3'(RES_MAX)) begin
            nb.res[bu.count[1:0]] = r;
            nb.count = bu.count + 3'd1;
        end
        return nb;
    endfunction

    // Operator resolution. n is the number of window bytes present; past the
    // query end (fin) a missing byte reads as zero, otherwise it is needed.
    function automatic t_decide op_decide(input logic [7:0] c0, input logic [7:0] c1,
                                          input logic [7:0] c2, input logic [1:0] n,
                                          input logic fin);
        t_decide    d;
        logic       miss1;
        logic       miss2;
        logic [7:0] d1;
        logic [7:0] d2;
        miss1 = (n < 2'd2) && !fin;
        miss2 = (n < 2'd3) && !fin;
        d1 = (n >= 2'd2) ? c1 : 8'h00;
        d2 = (n == 2'd3) ? c2 : 8'h00;
        d.need = 1'b0;
        d.kind = K_INV;
        d.len  = 2'd1;
        case (c0)
            "=": d.kind = K_EQ;
            "(": d.kind = K_LPAREN;
            ")": d.kind = K_RPAREN;
            ",": d.kind = K_COMMA;
            "[": d.kind = K_LBRACKET;
            "]": d.kind = K_RBRACKET;
            ">", "<": begin
                if (miss1) begin
                    d.need = 1'b1;
                end else if (d1 == "=") begin
                    d.len  = 2'd2;
                    d.kind = (c0 == ">") ? K_GE : K_LE;
                end else begin
                    d.kind = (c0 == ">") ? K_GT : K_LT;
                end
            end
            "~": begin
                if (miss1) begin
                    d.need = 1'b1;
                end else if (d1 == "~") begin
                    d.len  = 2'd2;
                    d.kind = K_FUZZY;
                end else begin
                    d.kind = K_SUBSTR;
                end
            end
            ".": begin
                if (miss1) begin
                    d.need = 1'b1;
                end else if (d1 == ".") begin
                    d.len  = 2'd2;
                    d.kind = K_DOTDOT;
                end
            end
            "^", "$", "%": begin
                if (miss1) begin
                    d.need = 1'b1;
                end else if (d1 == "~") begin
                    d.len  = 2'd2;
                    d.kind = (c0 == "^") ? K_STARTS : ((c0 == "$") ? K_ENDS : K_GLOB);
                end
            end
            "!": begin
                if (miss1) begin
                    d.need = 1'b1;
                end else if (d1 == "=") begin
                    d.len  = 2'd2;
                    d.kind = K_NE;
                end else if (!(d1 inside {"~", "%", "^", "$", "f", "g"})) begin
                    d.kind = K_INV;
                end else if (miss2) begin
                    d.need = 1'b1;
                end else if (d1 == "~") begin
                    if (d2 == "~") begin
                        d.len  = 2'd3;
                        d.kind = K_NFUZZY;
                    end else begin
                        d.len  = 2'd2;
                        d.kind = K_NSUBSTR;
                    end
                end else if (d2 == "~") begin
                    d.len = 2'd3;
                    if (d1 == "%" || d1 == "g") begin
                        d.kind = K_NGLOB;
                    end else if (d1 == "^") begin
                        d.kind = K_NSTARTS;
                    end else if (d1 == "$") begin
                        d.kind = K_NENDS;
                    end else begin
                        d.kind = K_NFUZZY;
                    end
                end
            end
            default: d.kind = K_INV;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

[hdl/qtl_in_if.sv]
`default_nettype none
interface qtl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       has_char;
    logic       end_of_query;

    modport source (output valid, output char_byte, output has_char,
                    output end_of_query, input ready);
    modport sink   (input valid, input char_byte, input has_char,
                    input end_of_query, output ready);
endinterface
`default_nettype wire

[hdl/qtl_out_if.sv]
`default_nettype none
interface qtl_out_if;
    logic        valid;
    logic        ready;
    logic        is_token;
    logic [5:0]  token_kind;
    logic [12:0] start_pos;
    logic [12:0] span_len;
    logic [7:0]  content_byte;
    logic        last_result;

    modport source (output valid, output is_token, output token_kind,
                    output start_pos, output span_len, output content_byte,
                    output last_result, input ready);
    modport sink   (input valid, input is_token, input token_kind,
                    input start_pos, input span_len, input content_byte,
                    input last_result, output ready);
endinterface
`default_nettype wire

[hdl/qtl_lex_core.sv]
`default_nettype none
module qtl_lex_core #(
    parameter int MAX_QUERY_LEN   = qtl_pkg::MAX_QUERY_LEN_DEF,
    parameter int KEYWORD_MAX_LEN = qtl_pkg::KEYWORD_MAX_LEN_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_go,
    input  wire qtl_pkg::t_item  i_item,
    output qtl_pkg::t_burst      o_burst
);
    import qtl_pkg::*;

    localparam int PW   = $clog2(MAX_QUERY_LEN + 1);
    localparam int KI_W = $clog2(KEYWORD_MAX_LEN);

    t_lex_mode     r_mode, n_mode;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_ts, n_ts;
    logic [PW-1:0] r_wlen, n_wlen;
    logic [7:0]    r_wbuf [KEYWORD_MAX_LEN];
    logic [7:0]    n_wbuf [KEYWORD_MAX_LEN];
    logic [7:0]    r_pend [2];
    logic [7:0]    n_pend [2];
    logic [1:0]    r_pcnt, n_pcnt;
    logic          r_quote, n_quote;

    logic          has_eff;
    logic          fin;
    logic          active;

    // Walk results.
    t_lex_mode     w_mode;
    logic [PW-1:0] w_ts, w_wlen, w_pos;
    logic [7:0]    w_wbuf [KEYWORD_MAX_LEN];
    logic [7:0]    w_pend [2];
    logic [1:0]    w_pcnt;
    logic          w_quote;
    t_burst        w_burst;

    // Keyword lookup on the word as it stands after this byte.
    logic          cand_app;
    logic [7:0]    cand_buf [KEYWORD_MAX_LEN];
    logic [PW:0]   cand_len;
    logic          kw_hit;
    logic [KIND_W-1:0] kw_kind;

    function automatic t_result mk_tok(input logic [KIND_W-1:0] kind, input logic [PW-1:0] st,
                                       input logic [PW-1:0] sp, input logic [7:0] cb);
        t_result r;
        r = '0;
        r.is_token     = 1'b1;
        r.token_kind   = kind;
        r.start_pos    = POS_W'(st);
        r.span_len     = POS_W'(sp);
        r.content_byte = cb;
        return r;
    endfunction

    function automatic logic [7:0] qget(input logic [2:0][7:0] q, input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = q[0];
            2'd1:    v = q[1];
            2'd2:    v = q[2];
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    assign fin     = i_item.end_of_query;
    assign has_eff = i_item.has_char && (r_pos < PW'(MAX_QUERY_LEN));
    assign active  = has_eff || fin;

    always_comb begin
        cand_app = (r_mode == LM_IDENT) && has_eff && is_word(i_item.char_byte);
        cand_buf = r_wbuf;
        if (cand_app && r_wlen < PW'(KEYWORD_MAX_LEN)) begin
            cand_buf[r_wlen[KI_W-1:0]] = i_item.char_byte;
        end
        cand_len = {1'b0, r_wlen} + (PW+1)'(cand_app);
        kw_hit  = 1'b0;
        kw_kind = K_STR;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            logic eq;
            eq = (cand_len == (PW+1)'(KW_LEN[i]));
            for (int j = 0; j < KW_TEXT_LEN; j++) begin
                if (j < int'(KW_LEN[i]) && cand_buf[j] != kw_char(i, j)) begin
                    eq = 1'b0;
                end
            end
            if (eq) begin
                kw_hit  = 1'b1;
                kw_kind = KIND_W'(KW_BASE + i);
            end
        end
    end

    // One pass over the byte window: held operator bytes first, then the new
    // byte. Each step consumes a byte, closes a token or ends an escape.
    always_comb begin
        t_lex_mode       mode;
        logic [PW-1:0]   ts, wlen, qs, p, pos_new;
        logic [7:0]      wbuf [KEYWORD_MAX_LEN];
        logic [7:0]      pend [2];
        logic [1:0]      pcnt, qn, qi, dl;
        logic            quote, kwok;
        logic [2:0][7:0] qb;
        logic [7:0]      b;
        t_decide         dc;
        t_burst          bu;

        mode    = r_mode;
        ts      = r_ts;
        wlen    = r_wlen;
        wbuf    = r_wbuf;
        pend    = r_pend;
        pcnt    = r_pcnt;
        quote   = r_quote;
        kwok    = (r_mode == LM_IDENT);
        qb      = '0;
        qn      = 2'd0;
        qi      = 2'd0;
        qs      = r_pos;
        p       = r_pos;
        b       = 8'h00;
        dl      = 2'd0;
        dc      = '0;
        bu      = '0;
        pos_new = r_pos + PW'(has_eff);

        if (r_mode == LM_OPS) begin
            qb[0] = r_pend[0];
            qb[1] = r_pend[1];
            qn    = r_pcnt;
            qs    = r_ts;
            pcnt  = 2'd0;
            mode  = LM_IDLE;
        end
        if (has_eff) begin
            case (qn)
                2'd0:    qb[0] = i_item.char_byte;
                2'd1:    qb[1] = i_item.char_byte;
                default: qb[2] = i_item.char_byte;
            endcase
            qn = qn + 2'd1;
        end

        for (int it = 0; it < WALK_STEPS; it++) begin
            if (qi < qn) begin
                b = qget(qb, qi);
                p = qs + PW'(qi);
                case (mode)
                    LM_NUM: begin
                        if (is_dig(b)) begin
                            qi = qi + 2'd1;
                        end else begin
                            bu   = push_res(bu, mk_tok(K_NUM, ts, p - ts, 8'h00));
                            mode = LM_IDLE;
                        end
                    end
                    LM_IDENT: begin
                        if (is_word(b)) begin
                            if (wlen < PW'(KEYWORD_MAX_LEN)) begin
                                wbuf[wlen[KI_W-1:0]] = b;
                            end
                            if (wlen < PW'(MAX_QUERY_LEN)) begin
                                wlen = wlen + PW'(1);
                            end
                            qi = qi + 2'd1;
                        end else begin
                            bu   = push_res(bu, mk_tok((kwok && kw_hit) ? kw_kind : K_STR,
                                                       ts, p - ts, 8'h00));
                            mode = LM_IDLE;
                        end
                    end
                    LM_QUOTE: begin
                        qi = qi + 2'd1;
                        if (b == (quote ? 8'h27 : 8'h22)) begin
                            bu   = push_res(bu, mk_tok(K_STR, ts, p + PW'(1) - ts, 8'h00));
                            mode = LM_IDLE;
                        end else if (b == "\\") begin
                            mode = LM_QESC;
                        end else begin
                            bu = push_res(bu, mk_byte(b));
                        end
                    end
                    LM_QESC: begin
                        mode = LM_QUOTE;
                        // An escaped zero byte leaves the backslash as content.
                        if (b != 8'h00) begin
                            bu = push_res(bu, mk_byte(b));
                            qi = qi + 2'd1;
                        end else begin
                            bu = push_res(bu, mk_byte("\\"));
                        end
                    end
                    default: begin
                        mode = LM_IDLE;
                        if (is_space(b)) begin
                            qi = qi + 2'd1;
                        end else if (is_dig(b)) begin
                            mode = LM_NUM;
                            ts   = p;
                            qi   = qi + 2'd1;
                        end else if (b == 8'h22 || b == 8'h27) begin
                            mode  = LM_QUOTE;
                            quote = (b == 8'h27);
                            ts    = p;
                            qi    = qi + 2'd1;
                        end else if (is_word_start(b)) begin
                            mode    = LM_IDENT;
                            ts      = p;
                            wbuf[0] = b;
                            wlen    = PW'(1);
                            kwok    = 1'b0;
                            qi      = qi + 2'd1;
                        end else begin
                            dc = op_decide(b, qget(qb, qi + 2'd1), qget(qb, qi + 2'd2),
                                           qn - qi, fin);
                            if (dc.need) begin
                                ts      = p;
                                pend[0] = b;
                                pend[1] = qget(qb, qi + 2'd1);
                                pcnt    = ((qn - qi) >= 2'd2) ? 2'd2 : 2'd1;
                                qi      = qn;
                                mode    = LM_OPS;
                            end else begin
                                dl = (dc.len > (qn - qi)) ? (qn - qi) : dc.len;
                                bu = push_res(bu, mk_tok(dc.kind, p, PW'(dl),
                                                         (dc.kind == K_INV) ? b : 8'h00));
                                qi = qi + dl;
                            end
                        end
                    end
                endcase
            end
        end

        if (fin) begin
            case (mode)
                LM_NUM: bu = push_res(bu, mk_tok(K_NUM, ts, pos_new - ts, 8'h00));
                LM_IDENT: bu = push_res(bu, mk_tok((kwok && kw_hit) ? kw_kind : K_STR,
                                                   ts, pos_new - ts, 8'h00));
                LM_QESC: begin
                    bu = push_res(bu, mk_byte("\\"));
                    bu = push_res(bu, mk_tok(K_INV, ts, pos_new - ts, 8'h00));
                end
                LM_QUOTE: bu = push_res(bu, mk_tok(K_INV, ts, pos_new - ts, 8'h00));
                default: ;
            endcase
            bu      = push_res(bu, mk_tok(K_END, pos_new, '0, 8'h00));
            mode    = LM_IDLE;
            pos_new = '0;
            ts      = '0;
            wlen    = '0;
            pcnt    = 2'd0;
            quote   = 1'b0;
        end

        w_mode  = mode;
        w_ts    = ts;
        w_wlen  = wlen;
        w_wbuf  = wbuf;
        w_pend  = pend;
        w_pcnt  = pcnt;
        w_quote = quote;
        w_pos   = pos_new;
        w_burst = bu;
    end

    // Next state: only an item that carries an in-range byte or an end mark moves it.
    always_comb begin
        if (i_go && active) begin
            n_mode  = w_mode;
            n_pos   = w_pos;
            n_ts    = w_ts;
            n_wlen  = w_wlen;
            n_wbuf  = w_wbuf;
            n_pend  = w_pend;
            n_pcnt  = w_pcnt;
            n_quote = w_quote;
        end else begin
            n_mode  = r_mode;
            n_pos   = r_pos;
            n_ts    = r_ts;
            n_wlen  = r_wlen;
            n_wbuf  = r_wbuf;
            n_pend  = r_pend;
            n_pcnt  = r_pcnt;
            n_quote = r_quote;
        end
    end

    // Outputs: the burst with its last record marked.
    always_comb begin
        o_burst = w_burst;
        if (!(i_go && active)) begin
            o_burst.count = 3'd0;
        end
        for (int k = 0; k < RES_MAX; k++) begin
            o_burst.res[k].last_result = (3'(k) + 3'd1 == o_burst.count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= LM_IDLE;
            r_pos   <= '0;
            r_ts    <= '0;
            r_wlen  <= '0;
            r_pcnt  <= 2'd0;
            r_quote <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_ts    <= n_ts;
            r_wlen  <= n_wlen;
            r_pcnt  <= n_pcnt;
            r_quote <= n_quote;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wbuf <= n_wbuf;
        r_pend <= n_pend;
    end

`ifndef SYNTHESIS
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && i_item.end_of_query |-> o_burst.count != 3'd0)
        else $error("query end produced no result");
    a_ops_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == LM_OPS |-> r_pcnt != 2'd0)
        else $error("operator wait with no held bytes");
    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && i_item.end_of_query |=> (r_pos == '0 && r_mode == LM_IDLE))
        else $error("state not cleared after query end");
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(MAX_QUERY_LEN))
        else $error("position past query limit");
`endif
endmodule
`default_nettype wire

[hdl/qtl_result_queue.sv]
`default_nettype none
module qtl_result_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire qtl_pkg::t_burst  i_push,
    input  wire logic             i_pop,
    output qtl_pkg::t_result      o_head,
    output logic [$clog2(qtl_pkg::QUEUE_DEPTH+1)-1:0] o_count
);
    import qtl_pkg::*;

    localparam int QI_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    t_result          r_q [QUEUE_DEPTH];
    logic [QI_W-1:0]  r_head, n_head;
    logic [QI_W-1:0]  r_tail, n_tail;
    logic [QC_W-1:0]  r_count, n_count;

    assign o_head  = r_q[r_head];
    assign o_count = r_count;

    always_comb begin
        n_head  = r_head + QI_W'(i_pop);
        n_tail  = r_tail + QI_W'(i_push.count);
        n_count = r_count + QC_W'(i_push.count) - QC_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RES_MAX; k++) begin
            if (3'(k) < i_push.count) begin
                r_q[r_tail + QI_W'(k)] <= i_push.res[k];
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QC_W'(QUEUE_DEPTH))
        else $error("result queue overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty result queue");
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        QI_W'(r_tail - r_head) == r_count[QI_W-1:0])
        else $error("queue pointers disagree with count");
`endif
endmodule
`default_nettype wire

[hdl/query_token_lexer.sv]
// Streaming query tokenizer.
// Input channel i_item: one beat per query byte (char_byte with has_char set),
// end_of_query set on the beat that closes the query, which may also be a bare
// end mark with has_char clear. A beat with neither flag is accepted and ignored.
// Output channel o_result: one beat per token record or per string content
// byte; last_result marks the final result caused by a given input beat, and
// every query ends with an end token.
// An accepted byte is registered, lexed in the next cycle, and its results are
// written to the result queue, from which o_result presents them.
// Throughput: one input beat per cycle while i_item.ready is high. Each beat
// yields up to four results, kept in a 16-entry result queue; ready drops
// only when the queue could not absorb the worst-case burst of the beat in
// flight plus one more. Results drain one per cycle when the receiver is ready.
// When the receiver stalls, results wait in the queue in order, and input is
// throttled once the queue nears full; nothing is dropped.
// Reset (synchronous, active low) empties the queue and returns the lexer to
// the start of a query at offset zero; no clearing pass is needed.
`default_nettype none
module query_token_lexer #(
    parameter int MAX_QUERY_LEN   = qtl_pkg::MAX_QUERY_LEN_DEF,
    parameter int KEYWORD_MAX_LEN = qtl_pkg::KEYWORD_MAX_LEN_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    qtl_in_if.sink     i_item,
    qtl_out_if.source  o_result
);
    import qtl_pkg::*;

    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    // Input register: the beat accepted last cycle, lexed this cycle.
    logic             r_item_valid;
    t_item            r_item;
    t_burst           burst;
    t_result          head;
    logic [QC_W-1:0]  q_count;
    logic             pop;
    logic             accept;

    // Room for the beat now in the input register and for one more.
    assign i_item.ready = ({1'b0, q_count} + (r_item_valid ? (QC_W+1)'(RES_MAX) : '0))
                          <= (QC_W+1)'(QUEUE_DEPTH - RES_MAX);
    assign accept = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else begin
            r_item_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.char_byte    <= i_item.char_byte;
            r_item.has_char     <= i_item.has_char;
            r_item.end_of_query <= i_item.end_of_query;
        end
    end

    qtl_lex_core #(
        .MAX_QUERY_LEN   (MAX_QUERY_LEN),
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_item_valid),
        .i_item  (r_item),
        .o_burst (burst)
    );

    assign pop = o_result.valid && o_result.ready;

    qtl_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (burst),
        .i_pop   (pop),
        .o_head  (head),
        .o_count (q_count)
    );

    assign o_result.valid        = (q_count != '0);
    assign o_result.is_token     = head.is_token;
    assign o_result.token_kind   = head.token_kind;
    assign o_result.start_pos    = head.start_pos;
    assign o_result.span_len     = head.span_len;
    assign o_result.content_byte = head.content_byte;
    assign o_result.last_result  = head.last_result;
endmodule
`default_nettype wire

[tb/query_token_lexer_tb.sv]
`timescale 1ns / 1ps
`default_nettype none
module query_token_lexer_tb;
    import qtl_pkg::*;

    localparam int QLEN = 4096;
    localparam int IDLE_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;

    qtl_in_if  item_ch ();
    qtl_out_if res_ch ();

    query_token_lexer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch.sink),
        .o_result(res_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Lexer state mirrored by the predictor.
    t_lex_mode  lx_mode;
    int         lx_pos;
    int         lx_start;
    logic [7:0] lx_word [KW_TEXT_LEN];
    int         lx_wlen;
    logic [7:0] lx_ops [2];
    int         lx_opcnt;
    logic       lx_squote;

    t_result expected_results[$];
    t_result beat_res[$];
    int errors;
    int items_sent;
    int results_seen;
    int tokens_seen;
    int idle_cycles;
    bit out_stall_on;

    function automatic void lexer_clear();
        lx_mode   = LM_IDLE;
        lx_pos    = 0;
        lx_start  = 0;
        lx_wlen   = 0;
        lx_opcnt  = 0;
        lx_squote = 1'b0;
    endfunction

    function automatic void add_res(logic tok, logic [5:0] kind, int st, int sp,
                                    logic [7:0] b);
        t_result r;
        r = '0;
        r.is_token     = tok;
        r.token_kind   = kind;
        r.start_pos    = st[12:0];
        r.span_len     = sp[12:0];
        r.content_byte = b;
        if (beat_res.size() < RES_MAX) beat_res.insert(beat_res.size(), r);
    endfunction

    function automatic logic is_ws(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic void word_close(int end_pos);
        logic [5:0] kind;
        logic       hit;
        kind = K_STR;
        if (lx_wlen <= KW_TEXT_LEN) begin
            for (int i = 0; i < KW_COUNT; i++) begin
                if (int'(KW_LEN[i]) == lx_wlen) begin
                    hit = 1'b1;
                    for (int j = 0; j < lx_wlen; j++)
                        if (KW_TEXT[i][(lx_wlen - 1 - j) * 8 +: 8] != lx_word[j]) hit = 1'b0;
                    if (hit && kind == K_STR) kind = 6'(KW_BASE + i);
                end
            end
        end
        add_res(1'b1, kind, lx_start, end_pos - lx_start, 8'h00);
        lx_mode = LM_IDLE;
    endfunction

    // Operator resolution over the window w[0..n-1]; returns -1 when more
    // bytes are needed.
    function automatic int op_kind(logic [7:0] w [3], int n, bit fin, output int len);
        int c1, c2;
        len = 1;
        c1 = (n > 1) ? int'(w[1]) : (fin ? 0 : -1);
        c2 = (n > 2) ? int'(w[2]) : (fin ? 0 : -1);
        case (w[0])
            "=": return K_EQ;
            "(": return K_LPAREN;
            ")": return K_RPAREN;
            ",": return K_COMMA;
            "[": return K_LBRACKET;
            "]": return K_RBRACKET;
            ">", "<", "~", "^", "$", "%", ".": begin
                if (c1 < 0) return -1;
                if (w[0] == ">" || w[0] == "<") begin
                    if (c1 == "=") begin
                        len = 2;
                        return (w[0] == ">") ? K_GE : K_LE;
                    end
                    return (w[0] == ">") ? K_GT : K_LT;
                end
                if (w[0] == "~") begin
                    if (c1 == "~") begin len = 2; return K_FUZZY; end
                    return K_SUBSTR;
                end
                if (w[0] == ".") begin
                    if (c1 == ".") begin len = 2; return K_DOTDOT; end
                    return K_INV;
                end
                if (c1 != "~") return K_INV;
                len = 2;
                return (w[0] == "^") ? K_STARTS : ((w[0] == "$") ? K_ENDS : K_GLOB);
            end
            "!": begin
                if (c1 < 0) return -1;
                if (c1 == "=") begin len = 2; return K_NE; end
                if (!(c1 == "~" || c1 == "%" || c1 == "^" || c1 == "$" ||
                      c1 == "f" || c1 == "g")) return K_INV;
                if (c2 < 0) return -1;
                if (c1 == "~") begin
                    if (c2 == "~") begin len = 3; return K_NFUZZY; end
                    len = 2;
                    return K_NSUBSTR;
                end
                if (c2 != "~") return K_INV;
                len = 3;
                if (c1 == "%" || c1 == "g") return K_NGLOB;
                if (c1 == "^") return K_NSTARTS;
                if (c1 == "$") return K_NENDS;
                return K_NFUZZY;
            end
            default: return K_INV;
        endcase
    endfunction

    // Computes the results one beat causes and queues them.
    function automatic void predict_tokens(logic [7:0] c, logic has, logic fin);
        logic [7:0] w [3];
        logic [7:0] b;
        logic [7:0] tail [3];
        int qn, qi, qs, p, len, kind;
        qn = 0;
        qi = 0;
        qs = lx_pos;
        beat_res.delete();
        if (has && lx_pos >= QLEN) has = 1'b0;
        if (!has && !fin) return;
        if (lx_mode == LM_OPS) begin
            for (int k = 0; k < lx_opcnt && k < 2; k++) begin
                w[qn] = lx_ops[k];
                qn++;
            end
            qs = lx_start;
            lx_opcnt = 0;
            lx_mode = LM_IDLE;
        end
        if (has) begin
            w[qn] = c;
            qn++;
            lx_pos++;
        end
        while (qi < qn) begin
            b = w[qi];
            p = qs + qi;
            case (lx_mode)
                LM_NUM: begin
                    if (is_num(b)) qi++;
                    else begin
                        add_res(1'b1, K_NUM, lx_start, p - lx_start, 8'h00);
                        lx_mode = LM_IDLE;
                    end
                end
                LM_IDENT: begin
                    if (is_num(b) || is_letter(b)) begin
                        if (lx_wlen < KW_TEXT_LEN) lx_word[lx_wlen] = b;
                        if (lx_wlen < QLEN) lx_wlen++;
                        qi++;
                    end else word_close(p);
                end
                LM_QUOTE: begin
                    qi++;
                    if (b == (lx_squote ? 8'h27 : 8'h22)) begin
                        add_res(1'b1, K_STR, lx_start, p + 1 - lx_start, 8'h00);
                        lx_mode = LM_IDLE;
                    end else if (b == 8'h5c) lx_mode = LM_QESC;
                    else add_res(1'b0, K_END, 0, 0, b);
                end
                LM_QESC: begin
                    lx_mode = LM_QUOTE;
                    if (b != 8'h00) begin
                        add_res(1'b0, K_END, 0, 0, b);
                        qi++;
                    end else add_res(1'b0, K_END, 0, 0, 8'h5c);
                end
                default: begin
                    lx_mode = LM_IDLE;
                    if (is_ws(b)) qi++;
                    else if (is_num(b)) begin
                        lx_mode = LM_NUM; lx_start = p; qi++;
                    end else if (b == 8'h22 || b == 8'h27) begin
                        lx_mode = LM_QUOTE; lx_squote = (b == 8'h27);
                        lx_start = p; qi++;
                    end else if (is_letter(b)) begin
                        lx_mode = LM_IDENT; lx_start = p;
                        lx_word[0] = b; lx_wlen = 1; qi++;
                    end else begin
                        for (int k = 0; k < 3; k++) tail[k] = (qi + k < qn) ? w[qi + k] : 8'h00;
                        kind = op_kind(tail, qn - qi, fin, len);
                        if (kind < 0) begin
                            lx_start = p;
                            lx_opcnt = 0;
                            while (qi < qn && lx_opcnt < 2) begin
                                lx_ops[lx_opcnt] = w[qi];
                                lx_opcnt++;
                                qi++;
                            end
                            qi = qn;
                            lx_mode = LM_OPS;
                        end else begin
                            if (len > qn - qi) len = qn - qi;
                            add_res(1'b1, 6'(kind), p, len, (kind == K_INV) ? b : 8'h00);
                            qi += len;
                        end
                    end
                end
            endcase
        end
        if (fin) begin
            case (lx_mode)
                LM_NUM:   add_res(1'b1, K_NUM, lx_start, lx_pos - lx_start, 8'h00);
                LM_IDENT: word_close(lx_pos);
                LM_QESC: begin
                    add_res(1'b0, K_END, 0, 0, 8'h5c);
                    add_res(1'b1, K_INV, lx_start, lx_pos - lx_start, 8'h00);
                end
                LM_QUOTE: add_res(1'b1, K_INV, lx_start, lx_pos - lx_start, 8'h00);
                default: ;
            endcase
            add_res(1'b1, K_END, lx_pos, 0, 8'h00);
            lexer_clear();
        end
        if (beat_res.size() > 0) beat_res[beat_res.size() - 1].last_result = 1'b1;
        foreach (beat_res[i]) expected_results.insert(expected_results.size(), beat_res[i]);
    endfunction

    // Sends one beat after a random gap; the prediction is made on acceptance.
    // Valid stays up after acceptance so that a beat with no gap follows at once.
    task automatic send_beat(logic [7:0] c, logic has, logic fin);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.char_byte    <= c;
        item_ch.has_char     <= has;
        item_ch.end_of_query <= fin;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        predict_tokens(c, has, fin);
        items_sent++;
    endtask

    task automatic send_text(string s, bit close_query);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b1, close_query && i == s.len() - 1);
    endtask

    task automatic end_query();
        send_beat(8'h00, 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Result checker; the receiver draws its own stall per beat.
    initial begin : result_check
        t_result exp_r;
        t_result got;
        int stall;
        res_ch.ready <= 1'b0;
        stall = 0;
        @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready) begin
                got.is_token     = res_ch.is_token;
                got.token_kind   = res_ch.token_kind;
                got.start_pos    = res_ch.start_pos;
                got.span_len     = res_ch.span_len;
                got.content_byte = res_ch.content_byte;
                got.last_result  = res_ch.last_result;
                results_seen++;
                if (got.is_token) tokens_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
                        errors++;
                    end
                end
                stall = out_stall_on ? $urandom_range(0, 6) : 0;
                if ($urandom_range(0, 3) == 0) stall = 0;
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                stall--;
            end else res_ch.ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any accepted beat.
    initial begin : watchdog
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("query_token_lexer regression: fail");
                $finish;
            end
        end
    end

    task automatic test_operators();
        send_text(">= > <= < = ~~ ~ ^~ $~ %~ ( ) , [ ] .. != ", 1'b0);
        send_text("!~~ !~ !%~ !^~ !$~ !f~ !g~ !x ^a . f~", 1'b1);
        send_text("!~", 1'b1);
        send_text(">", 1'b0);
        end_query();
    endtask

    task automatic test_keywords();
        send_text("priority tag status name path time deadline mtime any all ", 1'b0);
        send_text("untagged unstatused unnamed unprioritized undeadlined and or ", 1'b0);
        send_text("xor not allof anyof in has unprioritizedx _A9 12345678901", 1'b1);
    endtask

    task automatic test_strings();
        send_text("\"ab\\\"c\" 'x\"y' \"q\\", 1'b0);
        send_beat(8'h00, 1'b1, 1'b0);
        send_text("z\" \"open", 1'b1);
        send_text("'tail\\", 1'b1);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hff, 1'b1, 1'b0);
        send_beat(8'h80, 1'b0, 1'b0);
        send_beat(8'h7f, 1'b1, 1'b1);
        end_query();
    endtask

    function automatic string rand_fragment();
        string frag[] = '{"priority", "tag", "and", "or", "in", "has", "allof", "x1",
                          "unnamed", ">=", "<", "!~~", "!$~", "..", "(", ")", "[", "]",
                          ",", "~~", "%~", "!=", "42", "'s\\'t'", "\"a b\"", " ", "\t",
                          "!", "^", ".", "$~"};
        return frag[$urandom_range(0, frag.size() - 1)];
    endfunction

    task automatic test_random();
        string s;
        int n;
        for (int q = 0; q < 8; q++) begin
            if (q == 4) begin
                out_stall_on = 1'b0;
                wait_drained();
            end
            if (q == 6) out_stall_on = 1'b1;
            if ($urandom_range(0, 4) != 0) begin
                n = $urandom_range(1, 3);
                s = "";
                for (int k = 0; k < n; k++) s = {s, rand_fragment(), " "};
                send_text(s, 1'b0);
            end else begin
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++)
                    send_beat(8'($urandom_range(0, 255)), 1'($urandom), 1'b0);
            end
            if ($urandom_range(0, 1) == 0) send_beat(8'($urandom), 1'b1, 1'b1);
            else end_query();
        end
    endtask

    initial begin : main
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        tokens_seen = 0;
        out_stall_on = 1'b1;
        lexer_clear();
        item_ch.valid        <= 1'b0;
        item_ch.char_byte    <= 8'h00;
        item_ch.has_char     <= 1'b0;
        item_ch.end_of_query <= 1'b0;
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_operators();
        test_keywords();
        test_strings();
        test_random();
        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d input beats; checked %0d results, %0d of them tokens.",
                 items_sent, results_seen, tokens_seen);
        $display("Covered operators, keywords, strings, escapes, bad bytes and random queries.");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("query_token_lexer regression: pass");
        end else begin
            $display("query_token_lexer regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
hdl/qtl_pkg.sv
hdl/qtl_in_if.sv
hdl/qtl_out_if.sv
hdl/qtl_lex_core.sv
hdl/qtl_result_queue.sv
hdl/query_token_lexer.sv
tb/query_token_lexer_tb.sv
